@@ rtl/clie_pkg.sv @@
package clie_pkg;

  localparam int SAMPLE_W   = 16;
  localparam int FACTOR_W   = 5;
  localparam int EXTRA_W    = 4;
  localparam int MAX_FACTOR = 16;
  localparam int MAX_EXTRA  = 15;
  localparam int CNT_W      = 4;
  localparam int REM_W      = 4;
  localparam int DIFF_W     = SAMPLE_W + 1;
  localparam int ACC_W      = DIFF_W + FACTOR_W;
  localparam int DIV_CNT_W  = $clog2(SAMPLE_W);
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = FACTOR_W;

  localparam logic [CFG_IDX_W-1:0] CFG_INTERP_FACTOR = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_START_EXTRA   = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_END_EXTRA     = 2'd2;

  typedef struct packed {
    logic signed [SAMPLE_W-1:0] sample_i;
    logic signed [SAMPLE_W-1:0] sample_q;
    logic                       last_sample;
  } in_item_t;

  typedef struct packed {
    logic signed [SAMPLE_W-1:0] out_i;
    logic signed [SAMPLE_W-1:0] out_q;
    logic                       last_out;
  } out_item_t;

  typedef struct packed {
    logic store_first;
    logic load_sample;
    logic div_start;
    logic acc_clear;
    logic use_prev;
    logic use_b;
    logic step_fwd;
    logic step_back;
    logic emit;
    logic emit_last;
    logic commit;
  } clie_cmd_t;

  typedef struct packed {
    logic out_free;
    logic div_done;
  } clie_sts_t;

endpackage

@@ rtl/complex_linear_interpolator_extrap.sv @@
// the first result follows the bit-serial divider, which forms the step b-a over M,
// then any backward steps; results are registered before they leave the block
// a new item is taken only back in idle; N results go out one per cycle while the
// output is not stalled, S backward steps (start_extra) only on the second sample
// of a run; a non-last first sample is only stored, a lone sample emits one result
// reset: synchronous active-low rst_n clears control state and restores the registers
module complex_linear_interpolator_extrap (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            in_valid,
  output logic                            in_stall,
  input  clie_pkg::in_item_t              in_data,
  output logic                            out_valid,
  input  logic                            out_stall,
  output clie_pkg::out_item_t             out_data,
  input  logic                            cfg_valid,
  output logic                            cfg_ready,
  input  logic [clie_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [clie_pkg::CFG_DATA_W-1:0] cfg_data
);
  import clie_pkg::*;

  clie_cmd_t           cmd;
  clie_sts_t           sts;
  logic [FACTOR_W-1:0] factor;

  clie_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_last   (in_data.last_sample),
    .in_stall  (in_stall),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .sts       (sts),
    .cmd       (cmd),
    .factor    (factor)
  );

  clie_datapath u_dp (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_data   (in_data),
    .cmd       (cmd),
    .factor    (factor),
    .sts       (sts),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
  );

endmodule

@@ rtl/clie_ctrl.sv @@
module clie_ctrl (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           in_valid,
  input  logic                           in_last,
  output logic                           in_stall,
  input  logic                           cfg_valid,
  output logic                           cfg_ready,
  input  logic [clie_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [clie_pkg::CFG_DATA_W-1:0] cfg_data,
  input  clie_pkg::clie_sts_t            sts,
  output clie_pkg::clie_cmd_t            cmd,
  output logic [clie_pkg::FACTOR_W-1:0]  factor
);
  import clie_pkg::*;

  typedef enum logic [3:0] {
    ST_IDLE = 4'b0001,
    ST_DIV  = 4'b0010,
    ST_BACK = 4'b0100,
    ST_EMIT = 4'b1000
  } state_t;

  typedef enum logic [2:0] {
    PH_START = 3'b001,
    PH_MAIN  = 3'b010,
    PH_END   = 3'b100
  } phase_t;

  state_t               state_r, state_nxt;
  phase_t               phase_r, phase_nxt;
  logic [CNT_W-1:0]     cnt_r, cnt_nxt;
  logic [1:0]           seen_r, seen_nxt;
  logic                 last_r, last_nxt;
  logic                 lone_r, lone_nxt;
  logic [FACTOR_W-1:0]  factor_r;
  logic [EXTRA_W-1:0]   start_r, end_r;
  logic [FACTOR_W-1:0]  len;
  logic                 phase_end;

  assign cfg_ready = 1'b1;
  assign in_stall  = (state_r != ST_IDLE);

  // zero acts as one, anything above the maximum as the maximum
  always_comb begin
    if (factor_r == '0) begin
      factor = FACTOR_W'(1);
    end else if (factor_r > FACTOR_W'(MAX_FACTOR)) begin
      factor = FACTOR_W'(MAX_FACTOR);
    end else begin
      factor = factor_r;
    end
  end

  always_comb begin
    case (phase_r)
      PH_START: len = {1'b0, start_r};
      PH_MAIN:  len = factor;
      PH_END:   len = lone_r ? FACTOR_W'(1) : {1'b0, end_r};
      default:  len = factor;
    endcase
  end

  assign phase_end = ({1'b0, cnt_r} == len - FACTOR_W'(1));

  always_comb begin
    state_nxt = state_r;
    phase_nxt = phase_r;
    cnt_nxt   = cnt_r;
    seen_nxt  = seen_r;
    last_nxt  = last_r;
    lone_nxt  = lone_r;
    cmd       = '0;
    case (state_r)
      ST_IDLE: begin
        if (in_valid) begin
          last_nxt = in_last;
          cnt_nxt  = '0;
          if (seen_r == 2'd0) begin
            if (in_last) begin
              cmd.load_sample = 1'b1;
              cmd.acc_clear   = 1'b1;
              cmd.use_b       = 1'b1;
              lone_nxt        = 1'b1;
              phase_nxt       = PH_END;
              state_nxt       = ST_EMIT;
            end else begin
              cmd.store_first = 1'b1;
              seen_nxt        = 2'd1;
            end
          end else begin
            cmd.load_sample = 1'b1;
            cmd.div_start   = 1'b1;
            cmd.acc_clear   = 1'b1;
            cmd.use_prev    = 1'b1;
            lone_nxt        = 1'b0;
            state_nxt       = ST_DIV;
          end
        end
      end
      ST_DIV: begin
        if (sts.div_done) begin
          cnt_nxt = '0;
          if (seen_r == 2'd1 && start_r != '0) begin
            state_nxt = ST_BACK;
          end else begin
            phase_nxt = PH_MAIN;
            state_nxt = ST_EMIT;
          end
        end
      end
      ST_BACK: begin
        cmd.step_back = 1'b1;
        if (cnt_r == start_r - EXTRA_W'(1)) begin
          cnt_nxt   = '0;
          phase_nxt = PH_START;
          state_nxt = ST_EMIT;
        end else begin
          cnt_nxt = cnt_r + CNT_W'(1);
        end
      end
      ST_EMIT: begin
        if (sts.out_free) begin
          cmd.emit     = 1'b1;
          cmd.step_fwd = 1'b1;
          cmd.emit_last = phase_end && ((phase_r == PH_END) ||
                          (phase_r == PH_MAIN && last_r && end_r == '0));
          if (phase_end) begin
            cnt_nxt = '0;
            case (phase_r)
              PH_START: phase_nxt = PH_MAIN;
              PH_MAIN: begin
                if (last_r && end_r != '0) begin
                  phase_nxt     = PH_END;
                  cmd.acc_clear = 1'b1;
                  cmd.use_b     = 1'b1;
                end else begin
                  cmd.commit = 1'b1;
                  seen_nxt   = last_r ? 2'd0 : 2'd2;
                  state_nxt  = ST_IDLE;
                end
              end
              default: begin
                cmd.commit = 1'b1;
                seen_nxt   = 2'd0;
                state_nxt  = ST_IDLE;
              end
            endcase
          end else begin
            cnt_nxt = cnt_r + CNT_W'(1);
          end
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r  <= ST_IDLE;
      phase_r  <= PH_MAIN;
      cnt_r    <= '0;
      seen_r   <= '0;
      last_r   <= 1'b0;
      lone_r   <= 1'b0;
      factor_r <= FACTOR_W'(1);
      start_r  <= '0;
      end_r    <= '0;
    end else begin
      state_r <= state_nxt;
      phase_r <= phase_nxt;
      cnt_r   <= cnt_nxt;
      seen_r  <= seen_nxt;
      last_r  <= last_nxt;
      lone_r  <= lone_nxt;
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          CFG_INTERP_FACTOR: factor_r <= cfg_data;
          CFG_START_EXTRA:   start_r  <= cfg_data[EXTRA_W-1:0];
          CFG_END_EXTRA:     end_r    <= cfg_data[EXTRA_W-1:0];
          default: ;
        endcase
      end
    end
  end

endmodule

@@ rtl/clie_datapath.sv @@
module clie_datapath (
  input  logic                          clk,
  input  logic                          rst_n,
  input  clie_pkg::in_item_t            in_data,
  input  clie_pkg::clie_cmd_t           cmd,
  input  logic [clie_pkg::FACTOR_W-1:0] factor,
  output clie_pkg::clie_sts_t           sts,
  output logic                          out_valid,
  input  logic                          out_stall,
  output clie_pkg::out_item_t           out_data
);
  import clie_pkg::*;

  localparam int SUM_W = ACC_W + 1;
  localparam logic signed [SUM_W-1:0] SAT_HI = SUM_W'((64'sd1 <<< (SAMPLE_W - 1)) - 1);
  localparam logic signed [SUM_W-1:0] SAT_LO = -SAT_HI - SUM_W'(1);

  function automatic logic signed [SAMPLE_W-1:0] sat_point(
    input logic signed [SAMPLE_W-1:0] base,
    input logic signed [ACC_W-1:0]    acc
  );
    logic signed [SUM_W-1:0] s;
    s = SUM_W'(base) + SUM_W'(acc);
    if (s > SAT_HI) begin
      sat_point = SAT_HI[SAMPLE_W-1:0];
    end else if (s < SAT_LO) begin
      sat_point = SAT_LO[SAMPLE_W-1:0];
    end else begin
      sat_point = s[SAMPLE_W-1:0];
    end
  endfunction

  // lane 0 carries i, lane 1 carries q
  logic signed [SAMPLE_W-1:0] prev_r [2];
  logic signed [SAMPLE_W-1:0] b_r    [2];
  logic signed [SAMPLE_W-1:0] in_s   [2];
  logic signed [SAMPLE_W-1:0] base   [2];
  logic signed [DIFF_W-1:0]   diff   [2];
  logic [SAMPLE_W-1:0]        dvd_r  [2];
  logic [REM_W-1:0]           rem_r  [2];
  logic                       neg_r  [2];
  logic signed [ACC_W-1:0]    dq     [2];
  logic [REM_W-1:0]           dr     [2];
  logic signed [ACC_W-1:0]    q_r    [2];
  logic [REM_W-1:0]           r_r    [2];
  logic [REM_W:0]             trial  [2];
  logic                       ge     [2];
  logic [REM_W:0]             rs     [2];
  logic [REM_W:0]             rd     [2];
  logic [DIV_CNT_W-1:0]       div_cnt_r;
  logic                       div_busy_r;
  logic                       use_b_r;
  logic                       out_valid_r;
  out_item_t                  out_data_r;

  assign in_s[0] = in_data.sample_i;
  assign in_s[1] = in_data.sample_q;

  always_comb begin
    for (int l = 0; l < 2; l++) begin
      base[l]  = use_b_r ? b_r[l] : prev_r[l];
      diff[l]  = DIFF_W'(in_s[l]) - DIFF_W'(prev_r[l]);
      trial[l] = {rem_r[l], dvd_r[l][SAMPLE_W-1]};
      ge[l]    = (trial[l] >= factor);
      // floor division: negative with remainder borrows one from the quotient
      if (neg_r[l] && rem_r[l] != '0) begin
        dq[l] = ~ACC_W'(dvd_r[l]);
        dr[l] = REM_W'(factor - {1'b0, rem_r[l]});
      end else if (neg_r[l]) begin
        dq[l] = -ACC_W'(dvd_r[l]);
        dr[l] = '0;
      end else begin
        dq[l] = ACC_W'(dvd_r[l]);
        dr[l] = rem_r[l];
      end
      rs[l] = {1'b0, r_r[l]} + {1'b0, dr[l]};
      rd[l] = {1'b0, r_r[l]} - {1'b0, dr[l]};
    end
  end

  assign sts.div_done = div_busy_r && (div_cnt_r == DIV_CNT_W'(SAMPLE_W - 1));
  assign sts.out_free = !out_valid_r || !out_stall;

  always_ff @(posedge clk) begin
    for (int l = 0; l < 2; l++) begin
      if (cmd.store_first) begin
        prev_r[l] <= in_s[l];
      end else if (cmd.commit) begin
        prev_r[l] <= b_r[l];
      end
      if (cmd.load_sample) begin
        b_r[l] <= in_s[l];
      end
      if (cmd.div_start) begin
        neg_r[l] <= diff[l][DIFF_W-1];
        dvd_r[l] <= diff[l][DIFF_W-1] ? SAMPLE_W'(-diff[l]) : SAMPLE_W'(diff[l]);
        rem_r[l] <= '0;
      end else if (div_busy_r) begin
        dvd_r[l] <= {dvd_r[l][SAMPLE_W-2:0], ge[l]};
        rem_r[l] <= ge[l] ? REM_W'(trial[l] - factor) : REM_W'(trial[l]);
      end
      if (cmd.acc_clear) begin
        q_r[l] <= '0;
        r_r[l] <= '0;
      end else if (cmd.step_fwd) begin
        if (rs[l] >= factor) begin
          q_r[l] <= q_r[l] + dq[l] + ACC_W'(1);
          r_r[l] <= REM_W'(rs[l] - factor);
        end else begin
          q_r[l] <= q_r[l] + dq[l];
          r_r[l] <= REM_W'(rs[l]);
        end
      end else if (cmd.step_back) begin
        if (rd[l][REM_W]) begin
          q_r[l] <= q_r[l] - dq[l] - ACC_W'(1);
          r_r[l] <= REM_W'(rd[l] + factor);
        end else begin
          q_r[l] <= q_r[l] - dq[l];
          r_r[l] <= REM_W'(rd[l]);
        end
      end
    end
    if (cmd.emit) begin
      out_data_r.out_i    <= sat_point(base[0], q_r[0]);
      out_data_r.out_q    <= sat_point(base[1], q_r[1]);
      out_data_r.last_out <= cmd.emit_last;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      div_busy_r  <= 1'b0;
      div_cnt_r   <= '0;
      use_b_r     <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (cmd.div_start) begin
        div_busy_r <= 1'b1;
        div_cnt_r  <= '0;
      end else if (sts.div_done) begin
        div_busy_r <= 1'b0;
      end else if (div_busy_r) begin
        div_cnt_r <= div_cnt_r + DIV_CNT_W'(1);
      end
      if (cmd.use_b) begin
        use_b_r <= 1'b1;
      end else if (cmd.use_prev) begin
        use_b_r <= 1'b0;
      end
      if (cmd.emit) begin
        out_valid_r <= 1'b1;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

endmodule

@@ tb/complex_linear_interpolator_extrap_test.sv @@
`timescale 1ns / 1ps

module complex_linear_interpolator_extrap_test;
  import clie_pkg::*;

  // index with no register behind it, writes there are dropped
  localparam logic [CFG_IDX_W-1:0] CFG_SPARE = 2'd3;
  localparam int DRAIN_CYCLES = 24;
  localparam int STALL_LIMIT  = 3000;
  localparam int HOLD_CYCLES  = 400;
  localparam int HOLD_AT_ITEM = 30;
  localparam int PHASES       = 5;
  localparam int PHASE_ITEMS  = 19;

  typedef enum logic [1:0] {RUN_EMPTY, RUN_FIRST, RUN_ONGOING} run_state_t;
  typedef enum logic {ROW_SAMPLE, ROW_REG} row_kind_t;

  typedef struct {
    row_kind_t              kind;
    logic [CFG_IDX_W-1:0]   idx;
    logic [CFG_DATA_W-1:0]  val;
    in_item_t               smp;
    bit                     typed;
    int                     typed_n;
    out_item_t              res;
  } plan_row_t;

  logic                  clk;
  logic                  rst_n;
  logic                  in_valid;
  logic                  in_stall;
  in_item_t              in_data;
  logic                  out_valid;
  logic                  out_stall;
  out_item_t             out_data;
  logic                  cfg_valid;
  logic                  cfg_ready;
  logic [CFG_IDX_W-1:0]  cfg_index;
  logic [CFG_DATA_W-1:0] cfg_data;

  // predictor copy of the registers and the run state
  logic [FACTOR_W-1:0] factor_reg = 1;
  logic [EXTRA_W-1:0]  lead_reg = 0;
  logic [EXTRA_W-1:0]  tail_reg = 0;
  longint              held_i = 0;
  longint              held_q = 0;
  run_state_t          run_state = RUN_EMPTY;

  out_item_t step_points[$];
  out_item_t expected_points[$];
  plan_row_t plan[$];

  bit        cur_typed = 0;
  int        cur_typed_n = 0;
  out_item_t cur_typed_res = '0;

  int n_errors = 0;
  int n_taken = 0;
  int n_outputs = 0;
  int n_writes = 0;
  int quiet_cycles = 0;
  int burst_left = 0;

  complex_linear_interpolator_extrap DUT (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  initial clk = 1'b0;
  always #5 clk = ~clk;

  function automatic longint floor_div(longint n, longint d);
    longint q;
    q = n / d;
    if ((n % d) != 0 && n < 0) q--;
    return q;
  endfunction

  function automatic longint clip(longint v);
    longint hi;
    hi = (longint'(1) <<< (SAMPLE_W - 1)) - 1;
    if (v > hi) return hi;
    if (v < -hi - 1) return -hi - 1;
    return v;
  endfunction

  function automatic longint line_val(longint base, longint diff, longint k, longint m);
    return clip(base + floor_div(k * diff, m));
  endfunction

  function automatic void add_point(longint vi, longint vq, bit fin);
    out_item_t p;
    p.out_i = vi[SAMPLE_W-1:0];
    p.out_q = vq[SAMPLE_W-1:0];
    p.last_out = fin;
    step_points.push_back(p);
  endfunction

  // all points one input sample gives rise to, in output order
  function automatic void upsample_sample(in_item_t it);
    longint bi, bq, di, dq, m, k, lead, tail;
    step_points.delete();
    bi = longint'($signed(it.sample_i));
    bq = longint'($signed(it.sample_q));
    m = longint'(factor_reg);
    if (m < 1) m = 1;
    if (m > MAX_FACTOR) m = MAX_FACTOR;
    lead = longint'(lead_reg);
    tail = longint'(tail_reg);
    if (run_state == RUN_EMPTY) begin
      if (it.last_sample) begin
        add_point(bi, bq, 1'b1);
      end else begin
        held_i = bi;
        held_q = bq;
        run_state = RUN_FIRST;
      end
      return;
    end
    di = bi - held_i;
    dq = bq - held_q;
    // backward extension ahead of the first segment
    if (run_state == RUN_FIRST) begin
      for (k = -lead; k < 0; k++)
        add_point(line_val(held_i, di, k, m), line_val(held_q, dq, k, m), 1'b0);
    end
    for (k = 0; k < m; k++)
      add_point(line_val(held_i, di, k, m), line_val(held_q, dq, k, m),
                it.last_sample && tail == 0 && k == m - 1);
    if (it.last_sample) begin
      for (k = 0; k < tail; k++)
        add_point(line_val(bi, di, k, m), line_val(bq, dq, k, m), k == tail - 1);
      run_state = RUN_EMPTY;
    end else begin
      run_state = RUN_ONGOING;
    end
    held_i = bi;
    held_q = bq;
  endfunction

  task automatic report_mismatch(input string what);
    n_errors++;
    if (n_errors <= 40) $display("mismatch at %0t: %s", $time, what);
  endtask

  always @(posedge clk) begin
    out_item_t want;
    if (!rst_n) begin
      factor_reg = 1;
      lead_reg = 0;
      tail_reg = 0;
      held_i = 0;
      held_q = 0;
      run_state = RUN_EMPTY;
    end else begin
      if (out_valid && !out_stall) begin
        n_outputs++;
        if (expected_points.size() == 0) begin
          report_mismatch($sformatf("unexpected output %0d/%0d last %0b",
                                    $signed(out_data.out_i), $signed(out_data.out_q),
                                    out_data.last_out));
        end else begin
          want = expected_points.pop_front();
          if (out_data.out_i !== want.out_i)
            report_mismatch($sformatf("out_i %0d, wanted %0d",
                                      $signed(out_data.out_i), $signed(want.out_i)));
          if (out_data.out_q !== want.out_q)
            report_mismatch($sformatf("out_q %0d, wanted %0d",
                                      $signed(out_data.out_q), $signed(want.out_q)));
          if (out_data.last_out !== want.last_out)
            report_mismatch($sformatf("last_out %0b, wanted %0b",
                                      out_data.last_out, want.last_out));
        end
      end
      if (cfg_valid && cfg_ready) begin
        n_writes++;
        case (cfg_index)
          CFG_INTERP_FACTOR: factor_reg = cfg_data[FACTOR_W-1:0];
          CFG_START_EXTRA:   lead_reg = cfg_data[EXTRA_W-1:0];
          CFG_END_EXTRA:     tail_reg = cfg_data[EXTRA_W-1:0];
          default: ;
        endcase
      end
      if (in_valid && !in_stall) begin
        n_taken++;
        upsample_sample(in_data);
        if (cur_typed) begin
          for (int j = 0; j < cur_typed_n; j++) expected_points.push_back(cur_typed_res);
        end else begin
          foreach (step_points[j]) expected_points.push_back(step_points[j]);
        end
      end
    end
  end

  always @(posedge clk) begin
    if (!rst_n || (in_valid && !in_stall) || (out_valid && !out_stall) ||
        (cfg_valid && cfg_ready)) begin
      quiet_cycles = 0;
    end else begin
      quiet_cycles++;
      if (quiet_cycles >= STALL_LIMIT) begin
        $display("no handshake for %0d cycles, %0d outputs still owed",
                 STALL_LIMIT, expected_points.size());
        $display("status: fail");
        $finish;
      end
    end
  end

  // output side: stall pattern of its own, plus one long hold-off
  initial begin
    int left;
    int mode;
    bit held;
    out_stall <= 1'b0;
    left = 0;
    mode = 0;
    held = 0;
    forever begin
      @(negedge clk);
      if (!held && n_taken >= HOLD_AT_ITEM) begin
        held = 1;
        out_stall <= 1'b1;
        repeat (HOLD_CYCLES) @(negedge clk);
        out_stall <= 1'b0;
      end else begin
        if (left == 0) begin
          mode = $urandom_range(0, 2);
          left = $urandom_range(5, 60);
        end
        left--;
        case (mode)
          0: out_stall <= 1'b0;
          1: out_stall <= ($urandom_range(0, 3) == 0);
          default: out_stall <= ($urandom_range(0, 3) != 0);
        endcase
      end
    end
  end

  task automatic offer(input in_item_t it, input bit typed, input int typed_n,
                       input out_item_t typed_res);
    int gap;
    if (burst_left == 0) begin
      gap = $urandom_range(1, 10);
      burst_left = ($urandom_range(0, 4) == 0) ? 40 : $urandom_range(1, 12);
    end else begin
      gap = 0;
    end
    burst_left--;
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_data <= it;
    in_valid <= 1'b1;
    cur_typed <= typed;
    cur_typed_n <= typed_n;
    cur_typed_res <= typed_res;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    @(negedge clk);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx,
                           input logic [CFG_DATA_W-1:0] val);
    cfg_index <= idx;
    cfg_data <= val;
    cfg_valid <= 1'b1;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    @(negedge clk);
    cfg_valid <= 1'b0;
    @(negedge clk);
  endtask

  // wait for every owed output, then let the block finish any silent item
  task automatic settle();
    in_valid <= 1'b0;
    while (expected_points.size() != 0) @(negedge clk);
    repeat (DRAIN_CYCLES) @(negedge clk);
  endtask

  function automatic void plan_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] val);
    plan_row_t r;
    r.kind = ROW_REG;
    r.idx = idx;
    r.val = val;
    r.smp = '0;
    r.typed = 0;
    r.typed_n = 0;
    r.res = '0;
    plan.push_back(r);
  endfunction

  function automatic void plan_smp(longint si, longint sq, bit last, bit typed, int typed_n,
                                   longint ri, longint rq, bit rl);
    plan_row_t r;
    r.kind = ROW_SAMPLE;
    r.idx = '0;
    r.val = '0;
    r.smp.sample_i = si[SAMPLE_W-1:0];
    r.smp.sample_q = sq[SAMPLE_W-1:0];
    r.smp.last_sample = last;
    r.typed = typed;
    r.typed_n = typed_n;
    r.res.out_i = ri[SAMPLE_W-1:0];
    r.res.out_q = rq[SAMPLE_W-1:0];
    r.res.last_out = rl;
    plan.push_back(r);
  endfunction

  function automatic logic [SAMPLE_W-1:0] pick_value(logic [SAMPLE_W-1:0] near);
    case ($urandom_range(0, 5))
      0: return {1'b1, {(SAMPLE_W-1){1'b0}}};
      1: return {1'b0, {(SAMPLE_W-1){1'b1}}};
      2, 3: return near + SAMPLE_W'($urandom_range(0, 200)) - SAMPLE_W'(100);
      default: return SAMPLE_W'($urandom);
    endcase
  endfunction

  initial begin
    in_item_t              it;
    out_item_t             none;
    logic [SAMPLE_W-1:0]   pi, pq;
    logic [CFG_DATA_W-1:0] f, a, b;
    int                    run_left;
    rst_n = 1'b0;
    in_valid = 1'b0;
    in_data = '0;
    cfg_valid = 1'b0;
    cfg_index = '0;
    cfg_data = '0;
    none = '0;
    pi = '0;
    pq = '0;
    run_left = 0;

    // reset settings: factor 1, no extension
    plan_smp(-32768, 32767, 1, 1, 1, -32768, 32767, 1);
    plan_smp(32767, -32768, 1, 1, 1, 32767, -32768, 1);
    plan_smp(4660, -1, 0, 1, 0, 0, 0, 0);
    plan_smp(-7, 100, 1, 1, 1, 4660, -1, 1);
    // widest everything, full-scale swings into saturation
    plan_reg(CFG_INTERP_FACTOR, 16);
    plan_reg(CFG_START_EXTRA, 15);
    plan_reg(CFG_END_EXTRA, 31);
    plan_smp(-32768, 32767, 0, 1, 0, 0, 0, 0);
    plan_smp(32767, -32768, 0, 0, 0, 0, 0, 0);
    plan_smp(-32768, 32767, 1, 0, 0, 0, 0, 0);
    // factor 0 behaves as 1, no end extension
    plan_reg(CFG_INTERP_FACTOR, 0);
    plan_reg(CFG_END_EXTRA, 0);
    plan_smp(100, 200, 0, 1, 0, 0, 0, 0);
    plan_smp(-100, 50, 0, 0, 0, 0, 0, 0);
    plan_smp(300, -300, 1, 0, 0, 0, 0, 0);
    // factor above range clamps, spare index ignored
    plan_reg(CFG_INTERP_FACTOR, 31);
    plan_reg(CFG_SPARE, 5);
    plan_smp(5, -5, 1, 1, 1, 5, -5, 1);
    plan_smp(1, 1, 0, 1, 0, 0, 0, 0);
    plan_smp(-1, -1, 1, 0, 0, 0, 0, 0);
    plan_reg(CFG_INTERP_FACTOR, 3);
    plan_reg(CFG_START_EXTRA, 16);
    plan_reg(CFG_END_EXTRA, 15);
    plan_smp(1000, -1000, 0, 1, 0, 0, 0, 0);
    plan_smp(-2000, 2000, 1, 0, 0, 0, 0, 0);

    repeat (3) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    foreach (plan[r]) begin
      if (plan[r].kind == ROW_REG) begin
        settle();
        write_reg(plan[r].idx, plan[r].val);
      end else begin
        offer(plan[r].smp, plan[r].typed, plan[r].typed_n, plan[r].res);
      end
    end

    // phases end on an item count, so some settings change in the middle of a run
    for (int ph = 0; ph < PHASES; ph++) begin
      settle();
      case (ph)
        0: begin f = 16; a = 15; b = 15; end
        1: begin f = 1;  a = 0;  b = 0;  end
        2: begin f = 2;  a = 15; b = 0;  end
        default: begin
          f = CFG_DATA_W'($urandom_range(0, 31));
          a = CFG_DATA_W'($urandom_range(0, 31));
          b = CFG_DATA_W'($urandom_range(0, 31));
        end
      endcase
      write_reg(CFG_INTERP_FACTOR, f);
      write_reg(CFG_START_EXTRA, a);
      write_reg(CFG_END_EXTRA, b);
      for (int n = 0; n < PHASE_ITEMS; n++) begin
        if (run_left == 0) run_left = $urandom_range(1, 6);
        pi = pick_value(pi);
        pq = pick_value(pq);
        it.sample_i = pi;
        it.sample_q = pq;
        it.last_sample = (run_left == 1);
        if ($urandom_range(0, 9) == 0) it.last_sample = 1'($urandom_range(0, 1));
        run_left = it.last_sample ? 0 : run_left - 1;
        offer(it, 1'b0, 0, none);
      end
    end

    settle();
    $display("covered %0d input items, %0d output items and %0d register writes",
             n_taken, n_outputs, n_writes);
    $display("factors 0 to 31, edge extensions up to 15, lone samples, saturation,");
    $display("and a %0d-cycle output hold-off", HOLD_CYCLES);
    if (n_errors == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule

@@ sim.f @@
rtl/clie_pkg.sv
rtl/clie_ctrl.sv
rtl/clie_datapath.sv
rtl/complex_linear_interpolator_extrap.sv
tb/complex_linear_interpolator_extrap_test.sv
